FILE: sv/ptgs_pkg.sv
// ----------------------------------------------------------------------------
// ptgs_pkg - shared types and constants of the periodic trilinear sampler
// Field widths, configuration register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptgs_pkg;

  localparam int AXIS_MAX_DEF   = 16;
  localparam int GRID_WORDS_DEF = 4096;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SIZE_W    = 5;
  localparam int INDEX_W   = 12;
  localparam int VALUE_W   = 16;
  localparam int COORD_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_ROW,
    ST_READ,
    ST_WAIT
  } state_e;

  // corner bits: [2] z side, [1] y side, [0] x side
  typedef struct packed {
    logic       wr;
    logic       split;
    logic       base;
    logic       row;
    logic       rd;
    logic [2:0] corner;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic z_ready;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/ptgs_datapath.sv
// ----------------------------------------------------------------------------
// ptgs_datapath - grid store, axis split, corner addressing and interpolation
// Holds the size registers and the sample memory; runs the multiply-accumulate
// pipeline over the eight corners under control of ptgs_ctrl.
// ----------------------------------------------------------------------------
`default_nettype none

module ptgs_datapath import ptgs_pkg::*; #(
  parameter int AXIS_MAX   = AXIS_MAX_DEF,
  parameter int GRID_WORDS = GRID_WORDS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output stat_t                     stat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [SIZE_W-1:0]    cfg_data_i,
  input  wire logic [INDEX_W-1:0]   cell_index_i,
  input  wire logic [VALUE_W-1:0]   cell_value_i,
  input  wire logic [COORD_W-1:0]   coord_x_i,
  input  wire logic [COORD_W-1:0]   coord_y_i,
  input  wire logic [COORD_W-1:0]   coord_z_i,
  output logic [VALUE_W-1:0]        sampled_value_o
);

  localparam int F    = FRAC_BITS;
  localparam int WW   = F + 1;
  localparam int NW   = $clog2(AXIS_MAX + 1);
  localparam int IW   = (AXIS_MAX > 1) ? $clog2(AXIS_MAX) : 1;
  localparam int CUBE = AXIS_MAX * AXIS_MAX * AXIS_MAX;
  localparam int AW   = (CUBE > 1) ? $clog2(CUBE) : 1;
  localparam int MW   = (GRID_WORDS > 1) ? $clog2(GRID_WORDS) : 1;
  localparam int CW   = (AW > MW) ? AW : MW;
  localparam int XW   = (MW > INDEX_W) ? MW : INDEX_W;
  localparam int CUT  = (3 * F > 48) ? (3 * F - 48) : 0;
  localparam int FIN  = 3 * F - CUT;
  localparam int XVW  = VALUE_W + F;
  localparam int YW   = VALUE_W + 2 * F;
  localparam int YCW  = YW - CUT;
  localparam int ZW   = VALUE_W + FIN;
  localparam int PW   = F + NW;

  localparam logic [WW-1:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [ZW-1:0] HALF = ZW'(1) << (FIN - 1);

  function automatic logic [NW-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [NW-1:0] r;
    if (s == '0) begin
      r = NW'(1);
    end else if (32'(s) > 32'(AXIS_MAX)) begin
      r = NW'(AXIS_MAX);
    end else begin
      r = NW'(s);
    end
    return r;
  endfunction

  // configuration
  logic [SIZE_W-1:0] size_q [3];
  logic [NW-1:0]     n      [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SIZE_W'(1);
      size_q[1] <= SIZE_W'(1);
      size_q[2] <= SIZE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X: size_q[0] <= cfg_data_i;
        CFG_SIZE_Y: size_q[1] <= cfg_data_i;
        CFG_SIZE_Z: size_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      n[a] = eff_size(size_q[a]);
    end
  end

  // axis split: lower cell, upper cell (wrapping) and weight
  logic [F-1:0]  frac [3];
  logic [PW-1:0] p    [3];
  logic [NW-1:0] lo_c [3];
  logic [NW:0]   lo_p1[3];
  logic [IW-1:0] hi_c [3];
  logic [IW-1:0] lo_q [3];
  logic [IW-1:0] hi_q [3];
  logic [F-1:0]  w_q  [3];
  logic [WW-1:0] wl   [3];
  logic [WW-1:0] wh   [3];

  always_comb begin
    frac[0] = coord_x_i[F-1:0];
    frac[1] = coord_y_i[F-1:0];
    frac[2] = coord_z_i[F-1:0];
    for (int a = 0; a < 3; a++) begin
      p[a]     = PW'(frac[a]) * PW'(n[a]);
      lo_c[a]  = p[a][PW-1:F];
      lo_p1[a] = (NW+1)'(lo_c[a]) + (NW+1)'(1);
      if (lo_p1[a] >= (NW+1)'(n[a])) begin
        hi_c[a] = '0;
      end else begin
        hi_c[a] = IW'(lo_p1[a]);
      end
      wh[a] = {1'b0, w_q[a]};
      wl[a] = ONE - wh[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.split) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= IW'(lo_c[a]);
        hi_q[a] <= hi_c[a];
        w_q[a]  <= p[a][F-1:0];
      end
    end
  end

  // corner addressing: (x*ny + y)*nz + z, one multiply per stage
  logic [AW-1:0] bx_q  [2];
  logic [AW-1:0] row_q [2][2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.base) begin
      bx_q[0] <= AW'(AW'(lo_q[0]) * AW'(n[1]));
      bx_q[1] <= AW'(AW'(hi_q[0]) * AW'(n[1]));
    end
    if (cmd_i.row) begin
      for (int i = 0; i < 2; i++) begin
        row_q[i][0] <= AW'((bx_q[i] + AW'(lo_q[1])) * AW'(n[2]));
        row_q[i][1] <= AW'((bx_q[i] + AW'(hi_q[1])) * AW'(n[2]));
      end
    end
  end

  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_addr_ext;
  logic          rd_oob;
  logic [XW-1:0] wr_addr_ext;
  logic          wr_en;

  always_comb begin
    rd_addr     = row_q[cmd_i.corner[0]][cmd_i.corner[1]]
                + AW'(cmd_i.corner[2] ? hi_q[2] : lo_q[2]);
    rd_addr_ext = CW'(rd_addr);
    rd_oob      = 32'(rd_addr) >= 32'(GRID_WORDS);
    wr_addr_ext = XW'(cell_index_i);
    wr_en       = cmd_i.wr && (32'(cell_index_i) < 32'(GRID_WORDS));
  end

  // sample store
  logic [VALUE_W-1:0] mem [GRID_WORDS];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr_ext[MW-1:0]] <= cell_value_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_addr_ext[MW-1:0]];
    end
  end

  // interpolation pipeline: x pair, y pair, z pair
  logic               s1_v_q, s2_v_q, s3_v_q, z_ready_q;
  logic [2:0]         s1_tag_q;
  logic               s1_oob_q;
  logic [1:0]         s2_tag_q;
  logic               s3_k_q;
  logic [XVW-1:0]     xacc_q, xv_q;
  logic [YW-1:0]      yacc_q;
  logic [ZW-1:0]      zacc_q;
  logic [VALUE_W-1:0] out_q;
  logic [VALUE_W-1:0] v;
  logic [YW-1:0]      ymul;
  logic [YCW-1:0]     ycut;
  logic [ZW-1:0]      zmul;

  always_comb begin
    v    = s1_oob_q ? '0 : rdata_q;
    ymul = YW'(xv_q) * YW'(s2_tag_q[0] ? wh[1] : wl[1]);
    ycut = YCW'(yacc_q >> CUT);
    zmul = ZW'(ycut) * ZW'(s3_k_q ? wh[2] : wl[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      z_ready_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.rd;
      s2_v_q <= s1_v_q && s1_tag_q[0];
      s3_v_q <= s2_v_q && s2_tag_q[0];
      if (cmd_i.load_out) begin
        z_ready_q <= 1'b0;
      end else if (s3_v_q && s3_k_q) begin
        z_ready_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= cmd_i.corner;
    s1_oob_q <= rd_oob;
    if (s1_v_q) begin
      if (!s1_tag_q[0]) begin
        xacc_q <= XVW'(v) * XVW'(wl[0]);
      end else begin
        xv_q     <= xacc_q + XVW'(v) * XVW'(wh[0]);
        s2_tag_q <= s1_tag_q[2:1];
      end
    end
    if (s2_v_q) begin
      yacc_q <= (s2_tag_q[0] ? yacc_q : '0) + ymul;
      s3_k_q <= s2_tag_q[1];
    end
    if (s3_v_q) begin
      zacc_q <= (s3_k_q ? zacc_q : '0) + zmul;
    end
    if (cmd_i.load_out) begin
      out_q <= VALUE_W'((zacc_q + HALF) >> FIN);
    end
  end

  assign stat_o.z_ready  = z_ready_q;
  assign sampled_value_o = out_q;

endmodule

`default_nettype wire

FILE: sv/ptgs_ctrl.sv
// ----------------------------------------------------------------------------
// ptgs_ctrl - sequencer of the periodic trilinear sampler
// Accepts requests, steps the datapath through addressing and the eight
// corner reads, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ptgs_ctrl import ptgs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  mode_i,
  output logic       in_stall_o,
  input  wire logic  out_stall_i,
  output logic       out_valid_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_blocked = out_valid_q && out_stall_i;
    in_stall_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == MODE_QUERY) begin
            cmd_o.split = 1'b1;
            state_d     = ST_BASE;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_ROW;
      end
      ST_ROW: begin
        cmd_o.row = 1'b1;
        cnt_d     = '0;
        state_d   = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd     = 1'b1;
        cmd_o.corner = cnt_q;
        cnt_d        = 3'(cnt_q + 3'd1);
        if (cnt_q == 3'd7) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // hold the sum until the output register is free
        if (stat_i.z_ready && !out_blocked) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_blocked || cmd_o.load_out;
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a pending result");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !stat_i.z_ready)
    else $error("interpolation finished with no query in flight");

  a_rose_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.load_out))
    else $error("result valid without a load");

  a_read_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && cnt_q == 3'd7) |=> (state_q == ST_WAIT))
    else $error("corner sweep did not end after eight reads");
`endif

endmodule

`default_nettype wire

FILE: sv/periodic_trilinear_grid_sampler.sv
// ----------------------------------------------------------------------------
// periodic_trilinear_grid_sampler - 3D periodic grid with trilinear lookup
// Writes Q8.8 samples into a grid store and answers fixed-point queries with
// the rounded trilinear interpolation over the eight surrounding cells.
//
//   channel  handshake                 payload
//   input    in_valid_i / in_stall_o   mode, cell_index, cell_value, coord_x/y/z
//   output   out_valid_o / out_stall_i sampled_value
//   config   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A write is taken in the idle state, so writes can be accepted back to back.
// A query holds in_stall_o while it steps through the base, row, eight corner
// read and wait states; the eight corner reads share the single memory port.
// Reset is asynchronous and sets all sizes to 1; the grid store is not
// cleared. A stalled result holds in the output register; a following query
// waits at its final step until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_trilinear_grid_sampler import ptgs_pkg::*; #(
  parameter int AXIS_MAX   = AXIS_MAX_DEF,
  parameter int GRID_WORDS = GRID_WORDS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 mode_i,
  input  wire logic [INDEX_W-1:0]   cell_index_i,
  input  wire logic [VALUE_W-1:0]   cell_value_i,
  input  wire logic [COORD_W-1:0]   coord_x_i,
  input  wire logic [COORD_W-1:0]   coord_y_i,
  input  wire logic [COORD_W-1:0]   coord_z_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [VALUE_W-1:0]        sampled_value_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [SIZE_W-1:0]    cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  ptgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ptgs_datapath #(
    .AXIS_MAX   (AXIS_MAX),
    .GRID_WORDS (GRID_WORDS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cell_index_i    (cell_index_i),
    .cell_value_i    (cell_value_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .sampled_value_o (sampled_value_o)
  );

endmodule

`default_nettype wire
